@@ src/nps_pkg.sv @@
`timescale 1ns / 1ps

package nps_pkg;

    localparam int ARRIVAL_W  = 16;
    localparam int BURST_W    = 16;
    localparam int PRIORITY_W = 8;
    localparam int JOB_NUM_W  = 5;
    localparam int TIME_OUT_W = 21;

    typedef struct packed {
        logic [ARRIVAL_W-1:0]  arrival_time;
        logic [BURST_W-1:0]    burst_length;
        logic [PRIORITY_W-1:0] job_priority;
        logic                  last_job;
    } job_t;

    typedef struct packed {
        logic [JOB_NUM_W-1:0]  job_number;
        logic [TIME_OUT_W-1:0] completion_time;
        logic [TIME_OUT_W-1:0] turnaround_time;
        logic [TIME_OUT_W-1:0] waiting_time;
        logic                  last_result;
    } result_t;

    // One stored job record as the table holds it.
    typedef struct packed {
        logic [ARRIVAL_W-1:0]  arrival_time;
        logic [BURST_W-1:0]    burst_length;
        logic [PRIORITY_W-1:0] job_priority;
    } entry_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DECIDE,
        ST_ADD,
        ST_TAT,
        ST_EMIT
    } state_t;

    typedef enum logic {
        ALU_ADD,
        ALU_SUB
    } alu_op_t;

endpackage

@@ src/nps_job_store.sv @@
`timescale 1ns / 1ps

module nps_job_store #(
    parameter int DEPTH = 16,
    parameter int AW    = 4
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            wr_en,
    input  logic [AW-1:0]   wr_addr,
    input  nps_pkg::entry_t wr_entry,
    input  logic            rd_en,
    input  logic [AW-1:0]   rd_addr,
    input  logic            set_done,
    input  logic [AW-1:0]   done_addr,
    output nps_pkg::entry_t rd_entry,
    output logic            rd_done
);
    import nps_pkg::*;

    entry_t            mem [DEPTH];
    logic [DEPTH-1:0]  done_reg;
    entry_t            rd_entry_reg;
    logic              rd_done_reg;

    // Table memory: one write port for loading, one registered read port for the scan.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_entry;
        end
        if (rd_en)
        begin
            rd_entry_reg <= mem[rd_addr];
        end
    end

    // Done flags: cleared as an entry loads, set once the job is served.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg    <= '0;
            rd_done_reg <= 1'b0;
        end
        else
        begin
            if (wr_en)
            begin
                done_reg[wr_addr] <= 1'b0;
            end
            if (set_done)
            begin
                done_reg[done_addr] <= 1'b1;
            end
            if (rd_en)
            begin
                rd_done_reg <= done_reg[rd_addr];
            end
        end
    end

    assign rd_entry = rd_entry_reg;
    assign rd_done  = rd_done_reg;

endmodule

@@ src/nps_alu.sv @@
`timescale 1ns / 1ps

module nps_alu #(
    parameter int W = 21
) (
    input  nps_pkg::alu_op_t op,
    input  logic [W-1:0]     a,
    input  logic [W-1:0]     b,
    output logic [W-1:0]     y
);
    import nps_pkg::*;

    always_comb
    begin
        case (op)
            ALU_ADD: y = a + b;
            ALU_SUB: y = a - b;
            default: y = a + b;
        endcase
    end

endmodule

@@ src/nonpreemptive_priority_scheduler.sv @@
`timescale 1ns / 1ps

// Non-preemptive priority scheduler.
// Input channel: a job record on job is transferred at a rising edge where start
// is high and busy is low. Records load one per cycle into the job table; records
// past MAX_JOBS are dropped. A record with last_job set (stored or dropped) ends
// the batch and starts scheduling, with the schedule clock at 0.
// Output channel: each scheduled job appears on result for exactly one cycle with
// result_strobe high, in schedule order; last_result marks the final one. The
// receiver cannot stall, so every strobed result is taken as it is shown.
// Sequence: each pick scans the table through the single registered read port,
// for n loaded jobs: n reads, then a drain, a scan end and a decision.
// If nothing has arrived, the clock jumps to the earliest pending arrival and the
// scan runs once more. Then the shared add/subtract unit forms completion,
// turnaround and waiting times in turn, in states ADD, TAT and EMIT. Busy stays
// high from the last record to the final result. Reset clears the job count, done
// flags, clock and sequencer; the table contents are not cleared, since only
// entries of the current batch are read.
module nonpreemptive_priority_scheduler #(
    parameter int MAX_JOBS = 16
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    output logic             busy,
    input  nps_pkg::job_t    job,
    output nps_pkg::result_t result,
    output logic             result_strobe
);
    import nps_pkg::*;

    localparam int IW = (MAX_JOBS > 1) ? $clog2(MAX_JOBS) : 1;   // table index
    localparam int CW = $clog2(MAX_JOBS + 1);                    // job count
    localparam int TW = ARRIVAL_W + $clog2(MAX_JOBS + 1);        // schedule clock

    state_t                state_reg, state_next;
    logic [CW-1:0]         count_reg, count_next;
    logic [TW-1:0]         time_reg, time_next;
    logic [CW-1:0]         scan_ptr_reg, scan_ptr_next;
    logic                  rd_valid_reg, rd_valid_next;
    logic [IW-1:0]         rd_idx_reg, rd_idx_next;
    logic                  found_reg, found_next;
    logic [PRIORITY_W-1:0] best_prio_reg, best_prio_next;
    logic [IW-1:0]         pick_reg, pick_next;
    logic [ARRIVAL_W-1:0]  pick_arr_reg, pick_arr_next;
    logic [BURST_W-1:0]    pick_burst_reg, pick_burst_next;
    logic                  any_reg, any_next;
    logic [ARRIVAL_W-1:0]  next_arr_reg, next_arr_next;
    logic [CW-1:0]         emit_count_reg, emit_count_next;
    logic [TW-1:0]         tat_reg, tat_next;
    result_t               result_reg, result_next;
    logic                  result_strobe_reg, result_strobe_next;

    logic                  accept;
    logic                  load_en;
    logic                  scan_issue;
    logic                  scan_done;
    logic                  last_emit;
    logic                  cand_ok;
    logic                  earliest_ok;
    entry_t                wr_entry;
    entry_t                rd_entry;
    logic                  rd_done;
    alu_op_t               alu_op;
    logic [TW-1:0]         alu_a, alu_b, alu_y;
    logic [TW-1:0]         rd_arr_ext;
    logic [IW:0]           pick_plus_one;

    assign accept  = start && (state_reg == ST_IDLE);
    assign load_en = accept && (count_reg < CW'(MAX_JOBS));
    assign busy    = (state_reg != ST_IDLE);

    assign wr_entry.arrival_time = job.arrival_time;
    assign wr_entry.burst_length = job.burst_length;
    assign wr_entry.job_priority = job.job_priority;

    // Issue one table read per cycle until every loaded entry has been requested.
    assign scan_issue = (state_reg == ST_SCAN) && (scan_ptr_reg < count_reg);
    assign scan_done  = (state_reg == ST_SCAN) && !scan_issue && !rd_valid_reg;
    assign last_emit  = ((emit_count_reg + CW'(1)) == count_reg);

    assign rd_arr_ext = {{(TW-ARRIVAL_W){1'b0}}, rd_entry.arrival_time};

    // Candidate: arrived, not done, strictly better priority (earlier load wins ties).
    assign cand_ok = rd_valid_reg && !rd_done && (rd_arr_ext <= time_reg)
                     && (!found_reg || (rd_entry.job_priority < best_prio_reg));
    // Earliest pending arrival, used when nothing has arrived yet.
    assign earliest_ok = rd_valid_reg && !rd_done
                         && (!any_reg || (rd_entry.arrival_time < next_arr_reg));

    nps_job_store #(
        .DEPTH (MAX_JOBS),
        .AW    (IW)
    ) u_store (
        .clk       (clk),
        .rst_n     (rst_n),
        .wr_en     (load_en),
        .wr_addr   (count_reg[IW-1:0]),
        .wr_entry  (wr_entry),
        .rd_en     (scan_issue),
        .rd_addr   (scan_ptr_reg[IW-1:0]),
        .set_done  (state_reg == ST_EMIT),
        .done_addr (pick_reg),
        .rd_entry  (rd_entry),
        .rd_done   (rd_done)
    );

    // Operand select for the shared add/subtract unit.
    always_comb
    begin
        case (state_reg)
            ST_ADD:
            begin
                alu_op = ALU_ADD;
                alu_a  = time_reg;
                alu_b  = {{(TW-BURST_W){1'b0}}, pick_burst_reg};
            end
            ST_TAT:
            begin
                alu_op = ALU_SUB;
                alu_a  = time_reg;
                alu_b  = {{(TW-ARRIVAL_W){1'b0}}, pick_arr_reg};
            end
            default:
            begin
                alu_op = ALU_SUB;
                alu_a  = tat_reg;
                alu_b  = {{(TW-BURST_W){1'b0}}, pick_burst_reg};
            end
        endcase
    end

    nps_alu #(
        .W (TW)
    ) u_alu (
        .op (alu_op),
        .a  (alu_a),
        .b  (alu_b),
        .y  (alu_y)
    );

    assign pick_plus_one = {1'b0, pick_reg} + (IW+1)'(1);

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept && job.last_job)
                begin
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (scan_done)
                begin
                    state_next = ST_DECIDE;
                end
            end
            ST_DECIDE:
            begin
                state_next = found_reg ? ST_ADD : ST_SCAN;
            end
            ST_ADD:
            begin
                state_next = ST_TAT;
            end
            ST_TAT:
            begin
                state_next = ST_EMIT;
            end
            ST_EMIT:
            begin
                state_next = last_emit ? ST_IDLE : ST_SCAN;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Datapath and outputs.
    always_comb
    begin
        count_next         = count_reg;
        time_next          = time_reg;
        scan_ptr_next      = scan_ptr_reg;
        rd_valid_next      = scan_issue;
        rd_idx_next        = scan_ptr_reg[IW-1:0];
        found_next         = found_reg;
        best_prio_next     = best_prio_reg;
        pick_next          = pick_reg;
        pick_arr_next      = pick_arr_reg;
        pick_burst_next    = pick_burst_reg;
        any_next           = any_reg;
        next_arr_next      = next_arr_reg;
        emit_count_next    = emit_count_reg;
        tat_next           = tat_reg;
        result_next        = result_reg;
        result_strobe_next = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                if (load_en)
                begin
                    count_next = count_reg + CW'(1);
                end
                // Prime a fresh scan for the batch.
                time_next       = '0;
                scan_ptr_next   = '0;
                found_next      = 1'b0;
                any_next        = 1'b0;
                emit_count_next = '0;
            end
            ST_SCAN:
            begin
                if (scan_issue)
                begin
                    scan_ptr_next = scan_ptr_reg + CW'(1);
                end
                if (cand_ok)
                begin
                    found_next      = 1'b1;
                    best_prio_next  = rd_entry.job_priority;
                    pick_next       = rd_idx_reg;
                    pick_arr_next   = rd_entry.arrival_time;
                    pick_burst_next = rd_entry.burst_length;
                end
                if (earliest_ok)
                begin
                    any_next      = 1'b1;
                    next_arr_next = rd_entry.arrival_time;
                end
            end
            ST_DECIDE:
            begin
                // Nothing ready: jump the clock and rescan.
                if (!found_reg)
                begin
                    time_next     = {{(TW-ARRIVAL_W){1'b0}}, next_arr_reg};
                    scan_ptr_next = '0;
                    any_next      = 1'b0;
                end
            end
            ST_ADD:
            begin
                time_next = alu_y;
            end
            ST_TAT:
            begin
                tat_next = alu_y;
            end
            ST_EMIT:
            begin
                result_next.job_number      = JOB_NUM_W'(pick_plus_one);
                result_next.completion_time = TIME_OUT_W'(time_reg);
                result_next.turnaround_time = TIME_OUT_W'(tat_reg);
                result_next.waiting_time    = TIME_OUT_W'(alu_y);
                result_next.last_result     = last_emit;
                result_strobe_next          = 1'b1;
                emit_count_next             = emit_count_reg + CW'(1);
                scan_ptr_next               = '0;
                found_next                  = 1'b0;
                any_next                    = 1'b0;
                if (last_emit)
                begin
                    // Batch over: drop the job count and clock.
                    count_next = '0;
                    time_next  = '0;
                end
            end
            default:
            begin
                result_strobe_next = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg         <= ST_IDLE;
            count_reg         <= '0;
            time_reg          <= '0;
            scan_ptr_reg      <= '0;
            rd_valid_reg      <= 1'b0;
            found_reg         <= 1'b0;
            any_reg           <= 1'b0;
            emit_count_reg    <= '0;
            result_strobe_reg <= 1'b0;
        end
        else
        begin
            state_reg         <= state_next;
            count_reg         <= count_next;
            time_reg          <= time_next;
            scan_ptr_reg      <= scan_ptr_next;
            rd_valid_reg      <= rd_valid_next;
            found_reg         <= found_next;
            any_reg           <= any_next;
            emit_count_reg    <= emit_count_next;
            result_strobe_reg <= result_strobe_next;
        end
    end

    // Payload registers: no reset needed.
    always_ff @(posedge clk)
    begin
        rd_idx_reg     <= rd_idx_next;
        best_prio_reg  <= best_prio_next;
        pick_reg       <= pick_next;
        pick_arr_reg   <= pick_arr_next;
        pick_burst_reg <= pick_burst_next;
        next_arr_reg   <= next_arr_next;
        tat_reg        <= tat_next;
        result_reg     <= result_next;
    end

    assign result        = result_reg;
    assign result_strobe = result_strobe_reg;

endmodule
